// ===== rtl/core/x86_logic_shift_unit_defines.svh =====
// assertion macros shared by the logic and shift unit
`ifndef X86_LOGIC_SHIFT_UNIT_DEFINES_SVH
`define X86_LOGIC_SHIFT_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet during reset
`define XLSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define XLSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/xlsu_pkg.sv =====
// shared operation codes, flag type and width helpers for the logic and shift unit
`timescale 1ns / 1ps

package xlsu_pkg;

	// operation codes
	localparam logic [3:0] MODE_AND   = 4'd0;
	localparam logic [3:0] MODE_TEST  = 4'd1;
	localparam logic [3:0] MODE_OR    = 4'd2;
	localparam logic [3:0] MODE_XOR   = 4'd3;
	localparam logic [3:0] MODE_NOT   = 4'd4;
	localparam logic [3:0] MODE_SHL   = 4'd5;
	localparam logic [3:0] MODE_SHR   = 4'd6;
	localparam logic [3:0] MODE_SAR   = 4'd7;
	localparam logic [3:0] MODE_SHLD  = 4'd8;
	localparam logic [3:0] MODE_SHRD  = 4'd9;
	localparam logic [3:0] MODE_SETCC = 4'd10;

	// operand sizes, anything else is dword
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	// condition groups, cond[3:1]
	localparam logic [2:0] COND_O  = 3'd0;
	localparam logic [2:0] COND_B  = 3'd1;
	localparam logic [2:0] COND_E  = 3'd2;
	localparam logic [2:0] COND_BE = 3'd3;
	localparam logic [2:0] COND_S  = 3'd4;
	localparam logic [2:0] COND_P  = 3'd5;
	localparam logic [2:0] COND_L  = 3'd6;
	localparam logic [2:0] COND_LE = 3'd7;

	typedef struct packed {
		logic sf;
		logic zf;
		logic of;
		logic cf;
	} flags_t;

	localparam flags_t FLAGS_RESET = '0;

	// mask of the operand width
	function automatic logic [31:0] width_mask(input logic [1:0] size);
		logic [31:0] m;
		case (size)
			SIZE_BYTE: m = 32'h0000_00ff;
			SIZE_WORD: m = 32'h0000_ffff;
			default:   m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// top bit of the operand width
	function automatic logic msb_of(input logic [31:0] v, input logic [1:0] size);
		logic b;
		case (size)
			SIZE_BYTE: b = v[7];
			SIZE_WORD: b = v[15];
			default:   b = v[31];
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/xlsu_shifter.sv =====
// barrel shifter for shl, shr, sar, shld and shrd at byte, word or dword width
`timescale 1ns / 1ps

module xlsu_shifter import xlsu_pkg::*; (
	input  logic [3:0]  mode,
	input  logic [1:0]  size,
	input  logic [31:0] d,     // masked destination
	input  logic [31:0] f,     // masked fill operand
	input  logic [4:0]  cnt,
	output logic [31:0] res    // masked to width
);

	logic [31:0] m;
	logic [31:0] sext;
	logic [63:0] cat_l;
	logic [63:0] cat_r;
	logic [63:0] sh_l;
	logic [63:0] sh_r;
	logic [31:0] dbl_l;
	logic [31:0] raw;

	assign m = width_mask(size);

	// sign-extend the operand to 32 bits for sar
	assign sext = msb_of(d, size) ? (d | ~m) : d;

	always_comb begin
		case (size)
			SIZE_BYTE: begin
				cat_l = {48'd0, d[7:0], f[7:0]};
				cat_r = {48'd0, f[7:0], d[7:0]};
			end
			SIZE_WORD: begin
				cat_l = {32'd0, d[15:0], f[15:0]};
				cat_r = {32'd0, f[15:0], d[15:0]};
			end
			default: begin
				cat_l = {d, f};
				cat_r = {f, d};
			end
		endcase
	end

	assign sh_l = cat_l << cnt;
	assign sh_r = cat_r >> cnt;

	// upper half of the double-width window
	always_comb begin
		case (size)
			SIZE_BYTE: dbl_l = {24'd0, sh_l[15:8]};
			SIZE_WORD: dbl_l = {16'd0, sh_l[31:16]};
			default:   dbl_l = sh_l[63:32];
		endcase
	end

	always_comb begin
		case (mode)
			MODE_SHL:  raw = d << cnt;
			MODE_SHR:  raw = d >> cnt;
			MODE_SAR:  raw = $unsigned($signed(sext) >>> cnt);
			MODE_SHLD: raw = dbl_l;
			MODE_SHRD: raw = sh_r[31:0];
			default:   raw = d;
		endcase
	end

	assign res = raw & m;

endmodule

// ===== rtl/core/xlsu_exec.sv =====
// execution datapath: logic ops, shifts, setcc and the flag update
`timescale 1ns / 1ps

module xlsu_exec import xlsu_pkg::*; (
	input  logic [3:0]  mode,
	input  logic [1:0]  size,
	input  logic [31:0] dest_value,
	input  logic [31:0] src_value,
	input  logic [31:0] fill_value,
	input  logic [3:0]  cond,
	input  flags_t      flags_in,
	output logic [31:0] result,
	output logic        write_back,
	output logic        unsupported,
	output flags_t      flags_out
);

	logic [31:0] m;
	logic [31:0] d;
	logic [31:0] s;
	logic [31:0] f;
	logic [4:0]  cnt;
	logic [31:0] shift_res;
	logic        cc_raw;
	logic        cc_p;
	logic        cc_hit;

	assign m   = width_mask(size);
	assign d   = dest_value & m;
	assign s   = src_value & m;
	assign f   = fill_value & m;
	assign cnt = src_value[4:0];

	xlsu_shifter u_shifter (
		.mode (mode),
		.size (size),
		.d    (d),
		.f    (f),
		.cnt  (cnt),
		.res  (shift_res)
	);

	// condition evaluation from the stored flags, low bit inverts except for parity, which gives zero
	always_comb begin
		cc_p = 1'b0;
		case (cond[3:1])
			COND_O:  cc_raw = flags_in.of;
			COND_B:  cc_raw = flags_in.cf;
			COND_E:  cc_raw = flags_in.zf;
			COND_BE: cc_raw = flags_in.cf | flags_in.zf;
			COND_S:  cc_raw = flags_in.sf;
			COND_P: begin
				cc_raw = 1'b0;
				cc_p   = 1'b1;
			end
			COND_L:  cc_raw = flags_in.sf ^ flags_in.of;
			COND_LE: cc_raw = flags_in.zf | (flags_in.sf ^ flags_in.of);
			default: cc_raw = 1'b0;
		endcase
	end

	assign cc_hit = cc_p ? 1'b0 : (cc_raw ^ cond[0]);

	always_comb begin
		result      = '0;
		write_back  = 1'b1;
		unsupported = 1'b0;
		flags_out   = flags_in;
		case (mode) inside
			MODE_AND, MODE_TEST, MODE_OR, MODE_XOR: begin
				case (mode)
					MODE_OR:  result = d | s;
					MODE_XOR: result = d ^ s;
					default:  result = d & s;
				endcase
				write_back   = (mode != MODE_TEST);
				flags_out.cf = 1'b0;
				flags_out.of = 1'b0;
				flags_out.zf = (result == '0);
				flags_out.sf = msb_of(result, size);
			end
			MODE_NOT: begin
				result = ~d & m;
			end
			MODE_SHL, MODE_SHR, MODE_SAR, MODE_SHLD, MODE_SHRD: begin
				// zero count leaves operand and flags alone
				if (cnt == '0) begin
					result = d;
				end else begin
					result       = shift_res;
					flags_out.zf = (shift_res == '0);
					flags_out.sf = msb_of(shift_res, size);
				end
			end
			MODE_SETCC: begin
				result      = {31'd0, cc_hit};
				unsupported = cc_p;
			end
			default: begin
				write_back = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/x86_logic_shift_unit.sv =====
// top level of the x86 logic and shift unit: input register, datapath, result register
//
// usage
//  - input channel in_valid/in_ready carries one instruction per transaction:
//    mode, size, dest_value, src_value (shift count for shifts), fill_value, cond
//  - output channel out_valid/out_ready carries one result per transaction:
//    result, write_back, the four flags after the operation, unsupported
//  - an input transaction goes into the input register and then into the result
//    register, which drives out_valid; throughput is one transaction per cycle
//    while the receiver does not stall, set by the single pass through the
//    datapath between the input register and the result register
//  - the stored flags update when a transaction moves into the result
//    register, so setcc sees the flags left by the instruction just before it
//  - reset clears both valid bits and all stored flags
//  - when the receiver stalls, the result register holds; one more
//    transaction can still be taken into the input register, after which
//    in_ready drops until the result register frees up
`timescale 1ns / 1ps
`include "x86_logic_shift_unit_defines.svh"

module x86_logic_shift_unit import xlsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [1:0]  size,
	input  logic [31:0] dest_value,
	input  logic [31:0] src_value,
	input  logic [31:0] fill_value,
	input  logic [3:0]  cond,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        write_back,
	output logic        carry_out,
	output logic        overflow_out,
	output logic        zero_out,
	output logic        sign_out,
	output logic        unsupported
);

	// input register
	logic        valid_s1;
	logic [3:0]  mode_s1;
	logic [1:0]  size_s1;
	logic [31:0] dest_s1;
	logic [31:0] src_s1;
	logic [31:0] fill_s1;
	logic [3:0]  cond_s1;

	// result register and architectural flags
	logic        out_valid_q;
	logic [31:0] result_q;
	logic        write_back_q;
	logic        unsup_q;
	flags_t      out_flags_q;
	flags_t      flag_q;

	// datapath outputs
	logic [31:0] exec_result;
	logic        exec_wb;
	logic        exec_unsup;
	flags_t      exec_flags;

	logic        out_free;
	logic        advance;
	logic        in_take;

	// result register can load when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			size_s1 <= size;
			dest_s1 <= dest_value;
			src_s1  <= src_value;
			fill_s1 <= fill_value;
			cond_s1 <= cond;
		end
	end

	xlsu_exec u_exec (
		.mode        (mode_s1),
		.size        (size_s1),
		.dest_value  (dest_s1),
		.src_value   (src_s1),
		.fill_value  (fill_s1),
		.cond        (cond_s1),
		.flags_in    (flag_q),
		.result      (exec_result),
		.write_back  (exec_wb),
		.unsupported (exec_unsup),
		.flags_out   (exec_flags)
	);

	// output valid and the stored flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			flag_q      <= FLAGS_RESET;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				flag_q <= exec_flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q     <= exec_result;
			write_back_q <= exec_wb;
			unsup_q      <= exec_unsup;
			out_flags_q  <= exec_flags;
		end
	end

	assign out_valid    = out_valid_q;
	assign result       = result_q;
	assign write_back   = write_back_q;
	assign unsupported  = unsup_q;
	assign carry_out    = out_flags_q.cf;
	assign overflow_out = out_flags_q.of;
	assign zero_out     = out_flags_q.zf;
	assign sign_out     = out_flags_q.sf;

	// stored flags move only with a transaction into the result register
	`XLSU_ASSERT_NEXT(a_flags_hold, !advance, $stable(flag_q), "flags changed without a transaction")
	// a shown result always carries the flags that are stored
	`XLSU_ASSERT_NOW(a_flags_match, out_valid_q, out_flags_q == flag_q, "result flags differ from stored flags")
	// a parity setcc writes back a zero
	`XLSU_ASSERT_NOW(a_unsup_zero, out_valid_q && unsup_q, write_back_q && result_q == '0, "parity setcc result not zero")
	// an instruction leaving the input register shows up as a result next cycle
	`XLSU_ASSERT_NEXT(a_advance_out, advance, out_valid_q, "advanced transaction lost")

endmodule
